// ===== rtl/tilt_angle_change_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Tilt angle change detector assertion macros
// Shared concurrent assertion forms for the detector's checker.
// ----------------------------------------------------------------------------
`ifndef TILT_ANGLE_CHANGE_DETECTOR_MACROS_SVH
`define TILT_ANGLE_CHANGE_DETECTOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TACD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tacd assertion failed");

// Property checked on every clock edge, reset included.
`define TACD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tacd reset assertion failed");

`endif

// ===== rtl/tacd_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt angle change detector package
// Shared widths, codes, the CORDIC word type and the arctangent table.
// ----------------------------------------------------------------------------
package tacd_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 8;
  localparam int TAB_FRAC         = 16;
  localparam int TAB_LEN          = 24;
  localparam int IN_SHIFT         = 14;
  localparam int DIFF_W           = 17;
  localparam int SQ_W             = 32;
  localparam int SUM_W            = 33;
  localparam int ROOT_W           = 31;
  localparam int XW               = 35;
  localparam int ZW               = 25;
  localparam int SAMPLE_W         = 16;
  localparam int DATA_IN_W        = 48;
  localparam int DATA_OUT_W       = 40;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int THR_W            = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z,
    REG_THRESHOLD
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_START,
    ST_ROOT,
    ST_INJECT_X,
    ST_INJECT_Y,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic                 tag;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    case (i)
      0:       return 25'sd2949120;
      1:       return 25'sd1740967;
      2:       return 25'sd919879;
      3:       return 25'sd466945;
      4:       return 25'sd234379;
      5:       return 25'sd117304;
      6:       return 25'sd58666;
      7:       return 25'sd29335;
      8:       return 25'sd14668;
      9:       return 25'sd7334;
      10:      return 25'sd3667;
      11:      return 25'sd1833;
      12:      return 25'sd917;
      13:      return 25'sd458;
      14:      return 25'sd229;
      15:      return 25'sd115;
      16:      return 25'sd57;
      17:      return 25'sd29;
      18:      return 25'sd14;
      19:      return 25'sd7;
      20:      return 25'sd4;
      21:      return 25'sd2;
      22:      return 25'sd1;
      default: return 25'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/tacd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Tilt angle change detector square root
// Digit-by-digit integer square root of radicand * 2^28, one bit per cycle.
// ----------------------------------------------------------------------------
module tacd_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tacd_pkg::SUM_W-1:0]  radicand,
  output logic [tacd_pkg::ROOT_W-1:0] root,
  output logic                        done
);
  import tacd_pkg::*;

  localparam int N_W    = 2 * ROOT_W;
  localparam int PAD_LO = 28;
  localparam int PAD_HI = N_W - SUM_W - PAD_LO;
  localparam int REM_W  = ROOT_W + 4;
  localparam int CNT_W  = $clog2(ROOT_W);

  logic [N_W-1:0]   nsh;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  assign rem_sh = {rem[REM_W-3:0], nsh[N_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= {{PAD_HI{1'b0}}, radicand, {PAD_LO{1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      nsh  <= {nsh[N_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/tacd_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Tilt angle change detector CORDIC cell
// One vectoring rotation with a fixed shift; hands its word on every cycle.
// ----------------------------------------------------------------------------
module tacd_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  tacd_pkg::cordic_t din,
  output tacd_pkg::cordic_t dout
);
  import tacd_pkg::*;

  logic                 valid;
  logic                 tag;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] ang;

  assign dx  = din.ys >>> STAGE;
  assign dy  = din.xs >>> STAGE;
  assign ang = atan_tab(STAGE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    tag <= din.tag;
    if (!din.ys[XW-1]) begin
      xs <= din.xs + dx;
      ys <= din.ys - dy;
      z  <= din.z + ang;
    end else begin
      xs <= din.xs - dx;
      ys <= din.ys + dy;
      z  <= din.z - ang;
    end
  end

  assign dout = '{valid: valid, tag: tag, xs: xs, ys: ys, z: z};

endmodule

// ===== rtl/tilt_angle_change_detector.sv =====
// ----------------------------------------------------------------------------
// Tilt angle change detector
// Offset-corrected tilt angles from a three-axis sample, held with hysteresis.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         sample_x, sample_y, sample_z
// m_*       out        held_tilt_x, held_tilt_y, x_updated, y_updated, moved
// cfg_*     in         offset_x, offset_y, offset_z, change_threshold
//
// A sample is offset-corrected on acceptance, squared, passed through the
// bit-serial square roots and then through the CORDIC row, x before y.
// A new sample is taken the cycle after the previous result word is loaded,
// so a sample offered while the previous one is still in flight waits.
// A stalled result holds the final write-back and with it the next acceptance.
// Reset is synchronous and returns offsets to zero and the threshold to 5.
// ----------------------------------------------------------------------------
module tilt_angle_change_detector #(
  parameter int CORDIC_STEPS    = tacd_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = tacd_pkg::ANGLE_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sample_x[15:0], sample_y[31:16], sample_z[47:32]
  input  logic [tacd_pkg::DATA_IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // held_tilt_x[15:0], held_tilt_y[31:16], x_updated[32], y_updated[33],
  // moved[34], zero[39:35]
  output logic [tacd_pkg::DATA_OUT_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [tacd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tacd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tacd_pkg::*;

  localparam int ANG_W  = ANGLE_FRAC_BITS + 8;
  localparam int DIF_W  = ANG_W + 1;
  localparam int EXT_W  = (ANG_W > 16) ? ANG_W : 16;
  localparam int RND_SH = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int NSTEP  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam logic signed [ZW-1:0] LIM  = ZW'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [ZW-1:0] HALF = ZW'(1 << (RND_SH - 1));

  logic signed [SAMPLE_W-1:0] off_x, off_y, off_z;
  logic [THR_W-1:0]           thr;

  state_t state, state_next;

  logic signed [DIFF_W-1:0]   dif_x, dif_y, dif_z;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;
  logic [SQ_W-1:0]            sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]           sum_x, sum_y;
  logic [ROOT_W-1:0]          root_x, root_y;
  logic                       done_x, done_y;
  logic                       sq_start;
  logic                       inj_valid, inj_tag;
  logic                       do_out;
  logic                       out_free;
  logic                       accept;

  logic zn_x, zd_x, ng_x, zn_y, zd_y, ng_y;

  cordic_t link [0:NSTEP];
  cordic_t tail;

  logic signed [ZW-1:0]    zr, zc;
  logic                    sel_zn, sel_zd, sel_ng;
  logic signed [ANG_W-1:0] ang_final;
  logic signed [ANG_W-1:0] ang_x, ang_y;
  logic signed [ANG_W-1:0] stored_x, stored_y;
  logic signed [ANG_W-1:0] stored_x_next, stored_y_next;
  logic signed [DIF_W-1:0] dlt_x, dlt_y;
  logic [DIF_W-1:0]        abs_x, abs_y;
  logic [DIF_W-1:0]        thr_full;
  logic                    ux, uy;
  logic signed [EXT_W-1:0] ext_x, ext_y;
  logic signed [DIFF_W-1:0] num_sel;
  logic [ROOT_W-1:0]       den_sel;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
      thr   <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X:  off_x <= cfg_data;
        REG_OFFSET_Y:  off_y <= cfg_data;
        REG_OFFSET_Z:  off_z <= cfg_data;
        REG_THRESHOLD: thr   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    inj_valid  = 1'b0;
    inj_tag    = 1'b0;
    do_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        state_next = ST_ROOT_START;
      end
      ST_ROOT_START: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (done_x && done_y) state_next = ST_INJECT_X;
      end
      ST_INJECT_X: begin
        inj_valid  = 1'b1;
        state_next = ST_INJECT_Y;
      end
      ST_INJECT_Y: begin
        inj_valid  = 1'b1;
        inj_tag    = 1'b1;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tail.valid && tail.tag) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          do_out     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign prod_x = dif_x * dif_x;
  assign prod_y = dif_y * dif_y;
  assign prod_z = dif_z * dif_z;
  assign sum_x  = SUM_W'(sq_x) + SUM_W'(sq_y);
  assign sum_y  = SUM_W'(sq_x) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    if (accept) begin
      dif_x <= DIFF_W'($signed(s_tdata[15:0])) - DIFF_W'(off_x);
      dif_y <= DIFF_W'($signed(s_tdata[31:16])) - DIFF_W'(off_y);
      dif_z <= DIFF_W'($signed(s_tdata[47:32])) - DIFF_W'(off_z);
    end
    if (state == ST_SQUARE) begin
      sq_x <= prod_x[SQ_W-1:0];
      sq_y <= prod_y[SQ_W-1:0];
      sq_z <= prod_z[SQ_W-1:0];
    end
    if (sq_start) begin
      zn_x <= (dif_z == '0);
      zd_x <= (sum_x == '0);
      ng_x <= dif_z[DIFF_W-1];
      zn_y <= (dif_y == '0);
      zd_y <= (sum_y == '0);
      ng_y <= dif_y[DIFF_W-1];
    end
  end

  tacd_sqrt u_sqrt_x (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum_x),
    .root     (root_x),
    .done     (done_x)
  );

  tacd_sqrt u_sqrt_y (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sum_y),
    .root     (root_y),
    .done     (done_y)
  );

  assign num_sel = inj_tag ? dif_y : dif_z;
  assign den_sel = inj_tag ? root_y : root_x;

  assign link[0] = '{valid: inj_valid, tag: inj_tag,
                     xs: XW'(den_sel),
                     ys: XW'(num_sel) <<< IN_SHIFT,
                     z: '0};

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    tacd_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign tail = link[NSTEP];

  assign sel_zn = tail.tag ? zn_y : zn_x;
  assign sel_zd = tail.tag ? zd_y : zd_x;
  assign sel_ng = tail.tag ? ng_y : ng_x;
  assign zr     = (tail.z + HALF) >>> RND_SH;

  always_comb begin
    if (sel_zn) begin
      zc = '0;
    end else if (sel_zd) begin
      zc = sel_ng ? -LIM : LIM;
    end else if (zr > LIM) begin
      zc = LIM;
    end else if (zr < -LIM) begin
      zc = -LIM;
    end else begin
      zc = zr;
    end
  end

  assign ang_final = zc[ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      if (tail.tag) begin
        ang_y <= ang_final;
      end else begin
        ang_x <= ang_final;
      end
    end
  end

  assign thr_full = DIF_W'({thr, {ANGLE_FRAC_BITS{1'b0}}});
  assign dlt_x    = DIF_W'(ang_x) - DIF_W'(stored_x);
  assign dlt_y    = DIF_W'(ang_y) - DIF_W'(stored_y);
  assign abs_x    = dlt_x[DIF_W-1] ? DIF_W'(-dlt_x) : DIF_W'(dlt_x);
  assign abs_y    = dlt_y[DIF_W-1] ? DIF_W'(-dlt_y) : DIF_W'(dlt_y);
  assign ux       = abs_x > thr_full;
  assign uy       = abs_y > thr_full;
  assign stored_x_next = ux ? ang_x : stored_x;
  assign stored_y_next = uy ? ang_y : stored_y;
  assign ext_x    = EXT_W'(stored_x_next);
  assign ext_y    = EXT_W'(stored_y_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_x <= '0;
      stored_y <= '0;
      m_tvalid <= 1'b0;
    end else if (do_out) begin
      stored_x <= stored_x_next;
      stored_y <= stored_y_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      m_tdata <= {5'b00000, ux && uy, uy, ux, ext_y[15:0], ext_x[15:0]};
    end
  end

endmodule

// ===== rtl/tacd_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt angle change detector checker
// Port-level assertions on the detector, attached by bind.
// ----------------------------------------------------------------------------
`include "tilt_angle_change_detector_macros.svh"

module tacd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tacd_pkg::DATA_OUT_W-1:0] m_tdata
);
  import tacd_pkg::*;

  `TACD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `TACD_ASSERT(a_moved_both, m_tvalid |-> (m_tdata[34] == (m_tdata[32] && m_tdata[33])))
  `TACD_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready)
  `TACD_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid)

endmodule

bind tilt_angle_change_detector tacd_checker u_tacd_checker (.*);
